// ===== src/bnf_pkg.sv =====
// Shared types, widths, codes and helpers for the batch-norm weight folding block.
package bnf_pkg;

  // Field widths
  localparam int unsigned WEIGHT_WIDTH = 16;
  localparam int unsigned CH_W         = 16;
  localparam int unsigned FRAC_BITS    = 16;

  // Multiplier operand and product widths
  localparam int unsigned DIFF_W  = CH_W + 1;
  localparam int unsigned MUL_A_W = (WEIGHT_WIDTH > DIFF_W) ? WEIGHT_WIDTH : DIFF_W;
  localparam int unsigned SCALE_W = 32;
  localparam int unsigned PROD_W  = MUL_A_W + SCALE_W;
  localparam int unsigned RND_W   = PROD_W + 1 - FRAC_BITS;

  // Reciprocal square root unit sizes
  localparam int unsigned SQ_W        = 31;
  localparam int unsigned DEN_W       = 17;
  localparam int unsigned ROOT_W      = 25;
  localparam int unsigned DIV_STEPS   = 49;
  localparam int unsigned SQRT_STEPS  = 25;
  localparam int unsigned STEP_CNT_W  = 6;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_GAMMA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_BIAS    = 2'd2;

  // Gamma of one in Q4.12
  localparam logic [CH_W-1:0] GAMMA_ONE = 16'd4096;

  typedef struct packed {
    logic                           channel_start;
    logic signed [WEIGHT_WIDTH-1:0] weight_value;
    logic signed [CH_W-1:0]         gamma_value;
    logic signed [CH_W-1:0]         beta_value;
    logic signed [CH_W-1:0]         mean_value;
    logic        [CH_W-1:0]         variance_value;
    logic signed [CH_W-1:0]         bias_value;
  } bnf_in_t;

  typedef struct packed {
    logic signed [WEIGHT_WIDTH-1:0] scaled_weight;
    logic signed [CH_W-1:0]         folded_bias;
    logic                           bias_valid;
    logic                           saturated;
  } bnf_out_t;

  // Shift a Q.16 product right by 16, round to nearest, ties away from zero
  function automatic logic signed [RND_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
    logic [PROD_W:0] t;
    t = {p[PROD_W-1], p} + (p[PROD_W-1] ? (PROD_W+1)'(32767) : (PROD_W+1)'(32768));
    return $signed(t[PROD_W:FRAC_BITS]);
  endfunction

endpackage

// ===== src/batch_norm_fold_into_conv_weights.sv =====
// Top level: folds batch-norm scale and shift into convolution weights and bias.
//
//  channel   direction  handshake                  payload
//  in        sink       in_valid_i / in_ready_o    in_data_i   (bnf_in_t)
//  out       source     out_valid_o / out_ready_i  out_data_o  (bnf_out_t)
//  cfg       sink       cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
//  A weight-only beat steps through accept, one multiply, then round and saturate.
//  A channel-opening beat adds squaring, launch, the rsqrt core's shared subtractor for 49
//  divide steps and 25 root steps, then scale rounding, the bias multiply (skipped with
//  bias folding off) and the weight multiply on the shared multiplier.
//  Reset sets epsilon to one LSB, fixed gamma and bias folding on, scale to 0.
//  A new beat is taken while a result waits; the last step stalls while that register is full and not being taken.
module batch_norm_fold_into_conv_weights (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  bnf_pkg::bnf_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output bnf_pkg::bnf_out_t                 out_data_o,
  input  logic                              cfg_we_i,
  input  logic [bnf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bnf_pkg::CH_W-1:0]          cfg_data_i
);
  import bnf_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SQR    = 3'd1;
  localparam logic [2:0] ST_LAUNCH = 3'd2;
  localparam logic [2:0] ST_RSQ    = 3'd3;
  localparam logic [2:0] ST_SCALE  = 3'd4;
  localparam logic [2:0] ST_BMUL   = 3'd5;
  localparam logic [2:0] ST_BFIN   = 3'd6;
  localparam logic [2:0] ST_WFIN   = 3'd7;
  // weight multiply step gets its own code below, beyond the 3-bit codes
  localparam logic [3:0] ST_WMUL_N = 4'd8;

  localparam int unsigned W = WEIGHT_WIDTH;
  localparam logic signed [SCALE_W-1:0] SCALE_LIMIT = SCALE_W'(32'sd8388608);

  // State is one bit wider to hold the weight multiply step
  logic [3:0] state_q;

  logic [CH_W-1:0]           eps_q;
  logic                      fixed_gamma_q;
  logic                      has_bias_q;
  logic signed [SCALE_W-1:0] scale_q;
  logic                      out_valid_q;
  bnf_out_t                  out_q;
  logic                      bias_ok_q;

  bnf_in_t                   in_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [CH_W-1:0]    fb_q;
  logic                      bclip_q;

  logic                      in_beat;
  logic                      g_neg;
  logic [CH_W-1:0]           g_mag;
  logic [DEN_W-1:0]          den_sum, den;
  logic signed [DIFF_W-1:0]  bias_diff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [SCALE_W-1:0] mul_b;
  logic                      mul_en;

  logic                      rsq_start, rsq_done;
  logic [ROOT_W-1:0]         rsq_root;
  logic [ROOT_W-1:0]         scale_mag;
  logic [ROOT_W:0]           root_inc;

  logic signed [RND_W-1:0]   rnd;
  logic [RND_W-W:0]          w_hi;
  logic signed [W-1:0]       w_sat;
  logic                      w_clip;
  logic signed [RND_W:0]     b_sum;
  logic [RND_W-CH_W+1:0]     b_hi;
  logic signed [CH_W-1:0]    b_sat;
  logic                      b_clip;
  logic                      out_free;
  logic                      out_load;

  assign in_ready_o = (state_q == {1'b0, ST_IDLE});
  assign in_beat    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign out_load   = (state_q == {1'b0, ST_WFIN}) & out_free;

  // Gamma magnitude and sign, epsilon-padded variance
  assign g_neg     = ~fixed_gamma_q & in_q.gamma_value[CH_W-1];
  assign g_mag     = fixed_gamma_q ? GAMMA_ONE :
                     (g_neg ? CH_W'(-in_q.gamma_value) : in_q.gamma_value);
  assign den_sum   = DEN_W'(in_q.variance_value) + DEN_W'(eps_q);
  assign den       = (den_sum == '0) ? DEN_W'(1) : den_sum;
  assign bias_diff = DIFF_W'($signed(in_q.bias_value)) - DIFF_W'($signed(in_q.mean_value));

  // Route operands into the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = MUL_A_W'($signed(in_q.weight_value));
    mul_b  = scale_q;
    case (state_q)
      {1'b0, ST_SQR}: begin
        mul_en = 1'b1;
        mul_a  = $signed(MUL_A_W'(g_mag));
        mul_b  = $signed(SCALE_W'(g_mag));
      end
      {1'b0, ST_BMUL}: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(bias_diff);
      end
      ST_WMUL_N: begin
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Launch the reciprocal square root on the squared gamma
  assign rsq_start = (state_q == {1'b0, ST_LAUNCH});

  bnf_rsqrt u_rsqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rsq_start),
    .sq_i    (prod_q[SQ_W-1:0]),
    .den_i   (den),
    .done_o  (rsq_done),
    .root_o  (rsq_root)
  );

  // Round the doubled root to the Q15.16 scale magnitude
  assign root_inc  = {1'b0, rsq_root} + (ROOT_W+1)'(1);
  assign scale_mag = root_inc[ROOT_W:1];

  // Round and saturate the registered product
  assign rnd    = round_q16(prod_q);
  assign w_hi   = rnd[RND_W-1:W-1];
  assign w_clip = ~((&w_hi) | ~(|w_hi));
  assign w_sat  = w_clip ? {rnd[RND_W-1], {(W-1){~rnd[RND_W-1]}}} : rnd[W-1:0];

  assign b_sum  = (RND_W+1)'(rnd) + (RND_W+1)'($signed(in_q.beta_value));
  assign b_hi   = b_sum[RND_W:CH_W-1];
  assign b_clip = ~((&b_hi) | ~(|b_hi));
  assign b_sat  = b_clip ? {b_sum[RND_W], {(CH_W-1){~b_sum[RND_W]}}} : b_sum[CH_W-1:0];

  // Sequence, configuration and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= {1'b0, ST_IDLE};
      eps_q         <= CH_W'(1);
      fixed_gamma_q <= 1'b1;
      has_bias_q    <= 1'b1;
      scale_q       <= '0;
      out_valid_q   <= 1'b0;
      bias_ok_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_EPSILON:     eps_q         <= cfg_data_i;
          CFG_FIXED_GAMMA: fixed_gamma_q <= cfg_data_i[0];
          CFG_HAS_BIAS:    has_bias_q    <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      // Load a finished result, or drop the one taken by the sink
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        {1'b0, ST_IDLE}: begin
          if (in_beat) begin
            bias_ok_q <= 1'b0;
            state_q   <= in_data_i.channel_start ? {1'b0, ST_SQR} : ST_WMUL_N;
          end
        end
        {1'b0, ST_SQR}:    state_q <= {1'b0, ST_LAUNCH};
        {1'b0, ST_LAUNCH}: state_q <= {1'b0, ST_RSQ};
        {1'b0, ST_RSQ}: begin
          if (rsq_done) begin
            state_q <= {1'b0, ST_SCALE};
          end
        end
        {1'b0, ST_SCALE}: begin
          scale_q <= g_neg ? -SCALE_W'(scale_mag) : SCALE_W'(scale_mag);
          state_q <= has_bias_q ? {1'b0, ST_BMUL} : ST_WMUL_N;
        end
        {1'b0, ST_BMUL}: state_q <= {1'b0, ST_BFIN};
        {1'b0, ST_BFIN}: begin
          bias_ok_q <= 1'b1;
          state_q   <= ST_WMUL_N;
        end
        ST_WMUL_N: state_q <= {1'b0, ST_WFIN};
        {1'b0, ST_WFIN}: begin
          if (out_free) begin
            state_q <= {1'b0, ST_IDLE};
          end
        end
        default: state_q <= {1'b0, ST_IDLE};
      endcase
    end
  end

  // Capture the beat, the product and the results
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      in_q    <= in_data_i;
      fb_q    <= '0;
      bclip_q <= 1'b0;
    end
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (state_q == {1'b0, ST_BFIN}) begin
      fb_q    <= b_sat;
      bclip_q <= b_clip;
    end
    if ((state_q == {1'b0, ST_WFIN}) && out_free) begin
      out_q.scaled_weight <= w_sat;
      out_q.folded_bias   <= fb_q;
      out_q.bias_valid    <= bias_ok_q;
      out_q.saturated     <= w_clip | (bias_ok_q & bclip_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsq_done |-> state_q == {1'b0, ST_RSQ})
    else $error("rsqrt result arrived outside the wait step");
  a_scale_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scale_q <= SCALE_LIMIT) && (scale_q >= -SCALE_LIMIT))
    else $error("channel scale out of range");
  a_bias_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.bias_valid) |-> out_q.folded_bias == '0)
    else $error("folded bias nonzero without bias");
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == {1'b0, ST_WFIN}) && !out_valid_q) |=> out_valid_q)
    else $error("result not loaded into a free output register");
`endif

endmodule

// ===== src/bnf_rsqrt.sv =====
// Iterative reciprocal square root core: restoring divide then digit-by-digit root.
module bnf_rsqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bnf_pkg::SQ_W-1:0]    sq_i,
  input  logic [bnf_pkg::DEN_W-1:0]   den_i,
  output logic                        done_o,
  output logic [bnf_pkg::ROOT_W-1:0]  root_o
);
  import bnf_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DIV  = 2'd1;
  localparam logic [1:0] PH_SQRT = 2'd2;

  localparam int unsigned OP_W   = 28;
  localparam int unsigned WORK_W = 50;

  logic [1:0]            phase_q, phase_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [OP_W-1:0]       rem_q, rem_d;
  logic [WORK_W-1:0]     work_q, work_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic [DEN_W-1:0]      den_q, den_d;

  logic [OP_W-1:0] op_a, op_b;
  logic [OP_W:0]   diff;
  logic            ge;

  // Pick subtractor operands for the current phase
  always_comb begin
    if (phase_q == PH_SQRT) begin
      op_a = {rem_q[25:0], work_q[49:48]};
      op_b = {1'b0, root_q, 2'b01};
    end else begin
      op_a = {10'b0, rem_q[16:0], work_q[48]};
      op_b = {11'b0, den_q};
    end
  end

  // Shared subtractor: trial subtract and keep on no borrow
  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign ge   = ~diff[OP_W];

  // Step the sequencer
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    work_d  = work_q;
    root_d  = root_q;
    den_d   = den_q;
    case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          phase_d = PH_DIV;
          cnt_d   = '0;
          rem_d   = '0;
          work_d  = {1'b0, sq_i, 18'b0};
          root_d  = '0;
          den_d   = den_i;
        end
      end
      PH_DIV: begin
        rem_d  = ge ? diff[OP_W-1:0] : op_a;
        work_d = {1'b0, work_q[47:0], ge};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == STEP_CNT_W'(DIV_STEPS - 1)) begin
          phase_d = PH_SQRT;
          cnt_d   = '0;
          rem_d   = '0;
        end
      end
      PH_SQRT: begin
        rem_d  = ge ? diff[OP_W-1:0] : op_a;
        work_d = {work_q[47:0], 2'b00};
        root_d = {root_q[ROOT_W-2:0], ge};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == STEP_CNT_W'(SQRT_STEPS - 1)) begin
          phase_d = PH_IDLE;
          cnt_d   = '0;
          done_d  = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Hold datapath registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    work_q <= work_d;
    root_q <= root_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

`ifndef NO_ASSERTIONS
  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> phase_q == PH_IDLE)
    else $error("rsqrt started while busy");
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> phase_q == PH_IDLE)
    else $error("rsqrt done while still stepping");
  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DIV) |-> (rem_q < {11'b0, den_q}))
    else $error("division remainder not below divisor");
`endif

endmodule

// ===== dv/bnf_fold_checker.sv =====
// Checker for the batch-norm weight folding block: predicts each result beat and compares it.
module bnf_fold_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  bnf_pkg::bnf_in_t              in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  bnf_pkg::bnf_out_t             out_data_i,
  input  logic                          cfg_we_i,
  input  logic [bnf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bnf_pkg::CH_W-1:0]      cfg_data_i,
  output int unsigned                   in_beats_o,
  output int unsigned                   out_beats_o,
  output int unsigned                   errors_o
);
  import bnf_pkg::*;

  // Shadow copies of the register file and of the held channel scale
  logic [CH_W-1:0]    eps_q;
  logic               fixed_gamma_q;
  logic               has_bias_q;
  logic signed [31:0] scale_q;

  bnf_out_t expected_folds[$];

  // Floor square root, one result bit at a time; x stays below 2^50
  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 25; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // Channel scale g / sqrt(var + eps) in Q15.16, rounded half away from zero
  function automatic logic signed [31:0] channel_scale(input longint g,
                                                       input logic [CH_W-1:0] var_v,
                                                       input logic [CH_W-1:0] eps_v);
    longint unsigned s;
    longint unsigned mag;
    longint unsigned num;
    longint unsigned root;
    s = longint'(var_v) + longint'(eps_v);
    if (s == 0) s = 1;
    mag = (g < 0) ? longint'(-g) : longint'(g);
    num = mag * 512;
    root = (floor_root((num * num) / s) + 1) >> 1;
    return (g < 0) ? -32'(root) : 32'(root);
  endfunction

  // Product shifted right by 16, rounded half away from zero
  function automatic longint round_shift16(input longint a, input longint b);
    longint          p;
    longint unsigned m;
    p = a * b;
    m = (p < 0) ? longint'(-p) : longint'(p);
    m = (m + 32768) >> 16;
    return (p < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Clip to a signed width, flag the clip
  function automatic longint clamp(input longint v, input int unsigned w, inout bit clip);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clip = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clip = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Fold one input beat: update the held scale on a channel start, build the result
  function automatic bnf_out_t fold_beat(input bnf_in_t beat);
    bnf_out_t r;
    bit       clip;
    longint   g;
    longint   fb;
    r    = '0;
    clip = 1'b0;
    if (beat.channel_start) begin
      g = fixed_gamma_q ? longint'(GAMMA_ONE) : longint'(beat.gamma_value);
      scale_q = channel_scale(g, beat.variance_value, eps_q);
      if (has_bias_q) begin
        fb = round_shift16(longint'(beat.bias_value) - longint'(beat.mean_value),
                           longint'(scale_q)) + longint'(beat.beta_value);
        r.folded_bias = CH_W'(clamp(fb, CH_W, clip));
        r.bias_valid  = 1'b1;
      end
    end
    r.scaled_weight = WEIGHT_WIDTH'(clamp(round_shift16(longint'(beat.weight_value),
                                                        longint'(scale_q)),
                                          WEIGHT_WIDTH, clip));
    r.saturated = clip;
    return r;
  endfunction

  // Track config writes, queue predictions, compare result beats
  always @(posedge clk_i or negedge rst_ni) begin
    bnf_out_t want;
    if (!rst_ni) begin
      eps_q         = CH_W'(1);
      fixed_gamma_q = 1'b1;
      has_bias_q    = 1'b1;
      scale_q       = '0;
      expected_folds.delete();
      in_beats_o    <= 0;
      out_beats_o   <= 0;
      errors_o      <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_EPSILON:     eps_q = cfg_data_i;
          CFG_FIXED_GAMMA: fixed_gamma_q = cfg_data_i[0];
          CFG_HAS_BIAS:    has_bias_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_folds.push_back(fold_beat(in_data_i));
        in_beats_o <= in_beats_o + 1;
      end
      if (out_valid_i && out_ready_i) begin
        out_beats_o <= out_beats_o + 1;
        if (expected_folds.size() == 0) begin
          $display("%0t: unexpected result beat sw=%0d fb=%0d bv=%0b sat=%0b", $time,
                   out_data_i.scaled_weight, out_data_i.folded_bias,
                   out_data_i.bias_valid, out_data_i.saturated);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_folds.pop_front();
          if (want.scaled_weight !== out_data_i.scaled_weight ||
              want.folded_bias   !== out_data_i.folded_bias   ||
              want.bias_valid    !== out_data_i.bias_valid    ||
              want.saturated     !== out_data_i.saturated) begin
            $display({"%0t: mismatch expected sw=%0d fb=%0d bv=%0b sat=%0b,",
                      " got sw=%0d fb=%0d bv=%0b sat=%0b"},
                     $time, want.scaled_weight, want.folded_bias, want.bias_valid,
                     want.saturated, out_data_i.scaled_weight, out_data_i.folded_bias,
                     out_data_i.bias_valid, out_data_i.saturated);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top: drives weight and channel beats, config writes and output stalls.
module tb;
  import bnf_pkg::*;

  localparam int unsigned RAND_PHASES    = 5;
  localparam int unsigned PHASE_ITEMS    = 167;
  localparam int unsigned CFG_SETTLE     = 90;
  localparam int unsigned END_SETTLE     = 100;
  localparam int unsigned SQUEEZE_CYCLES = 400;
  localparam int unsigned SQUEEZE_AT     = 400;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  bnf_in_t              in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  bnf_out_t             out_data_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CH_W-1:0]      cfg_data_i;

  int unsigned in_beats;
  int unsigned out_beats;
  int unsigned errors;
  bit          steady;
  bit          squeezed;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  batch_norm_fold_into_conv_weights dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  bnf_fold_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_beats_o  (in_beats),
    .out_beats_o (out_beats),
    .errors_o    (errors)
  );

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Field value biased toward extremes and small magnitudes
  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'($urandom_range(0, 64));
      5:       return -16'($urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bnf_in_t chan_beat(input bit start, input logic [15:0] w,
                                        input logic [15:0] g, input logic [15:0] beta,
                                        input logic [15:0] mean, input logic [15:0] vr,
                                        input logic [15:0] bias);
    bnf_in_t b;
    b.channel_start  = start;
    b.weight_value   = w;
    b.gamma_value    = g;
    b.beta_value     = beta;
    b.mean_value     = mean;
    b.variance_value = vr;
    b.bias_value     = bias;
    return b;
  endfunction

  // Random beat: about one beat in six is a channel start
  function automatic bnf_in_t random_beat();
    return chan_beat($urandom_range(0, 5) == 0, pick_field(), pick_field(), pick_field(),
                     pick_field(), pick_field(), pick_field());
  endfunction

  // Offer one beat, hold it until accepted
  task automatic send_item(input bnf_in_t beat);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stop offering, wait for every outstanding result, then let the block settle
  task automatic drain(input int unsigned settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (in_beats != out_beats) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Write all three registers; call only while idle
  task automatic program_regs(input logic [CH_W-1:0] eps, input bit fg, input bit hb);
    drain(CFG_SETTLE);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_EPSILON;
    cfg_data_i <= eps;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FIXED_GAMMA;
    cfg_data_i <= CH_W'(fg);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HAS_BIAS;
    cfg_data_i <= CH_W'(hb);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Output side: random stalls, one long hold-off to back the block up
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!squeezed && out_beats >= SQUEEZE_AT) begin
        out_ready_i <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk_i);
        squeezed = 1'b1;
      end
      if (pick_gap() != 0) begin
        out_ready_i <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12))
        @(posedge clk_i);
    end
  end

  // Stimulus and verdict
  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CFG_EPSILON;
    cfg_data_i <= '0;
    steady     = 1'b0;
    squeezed   = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero epsilon, supplied gamma, bias folding on
    program_regs(16'h0000, 1'b0, 1'b1);
    // weight before any channel start: scale is still zero
    send_item(chan_beat(0, 16'h7FFF, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // zero variance and epsilon with max gamma: largest scale, bias clips high
    send_item(chan_beat(1, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF));
    send_item(chan_beat(0, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(chan_beat(0, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(chan_beat(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // most negative gamma, max variance, folded bias comes out zero
    send_item(chan_beat(1, 16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000));
    send_item(chan_beat(0, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // zero gamma gives zero scale
    send_item(chan_beat(1, 16'h1000, 16'h0000, 16'h0123, 16'h0456, 16'h0100, 16'h0789));
    send_item(chan_beat(0, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // unit gamma over unit variance
    send_item(chan_beat(1, 16'h1000, 16'h1000, 16'h0000, 16'h0000, 16'h0100, 16'h1000));
    // channel fields on a plain weight are ignored
    send_item(chan_beat(0, 16'hF000, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));

    // Max epsilon, fixed gamma, no bias
    program_regs(16'hFFFF, 1'b1, 1'b0);
    send_item(chan_beat(1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF));
    send_item(chan_beat(1, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(chan_beat(0, 16'h4321, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));

    // Reset values: epsilon of one LSB, fixed gamma, bias on
    program_regs(16'h0001, 1'b1, 1'b1);
    send_item(chan_beat(1, 16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h8000));
    send_item(chan_beat(0, 16'h0800, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(chan_beat(1, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));

    // Random phases, one register setting each
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       program_regs(16'h0000, 1'b0, 1'b1);
        1:       program_regs(16'hFFFF, 1'b0, 1'b1);
        2:       program_regs(16'($urandom), 1'b1, 1'b1);
        3:       program_regs(16'($urandom), 1'b0, 1'b0);
        default: program_regs(16'($urandom_range(0, 15)), 1'b0, 1'b1);
      endcase
      steady = (ph == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // pause the sender once until the block has emptied
        if (ph == 1 && k == PHASE_ITEMS / 2) drain(0);
        send_item(random_beat());
      end
    end

    drain(END_SETTLE);
    @(negedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/bnf_pkg.sv
src/bnf_rsqrt.sv
src/batch_norm_fold_into_conv_weights.sv
dv/bnf_fold_checker.sv
dv/tb.sv
